/* hw/rtl/prng_seed_and_next_unit_macros.svh */
// Assertion macros shared by the random-number unit's modules.
`ifndef PRNG_SEED_AND_NEXT_UNIT_MACROS_SVH
`define PRNG_SEED_AND_NEXT_UNIT_MACROS_SVH

`ifndef SYNTH
// Concurrent check that is switched off while reset is asserted.
`define PRNGSN_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("prngsn assertion failed");
// Concurrent check that also holds while reset is asserted.
`define PRNGSN_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("prngsn assertion failed");
`else
`define PRNGSN_ASSERT(lbl, clk, rstn, prop)
`define PRNGSN_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* hw/rtl/prngsn_pkg.sv */
// Types and constants of the random-number unit.
package prngsn_pkg;

    // Splitmix64 increment and mixing multipliers.
    localparam logic [63:0] K_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] K_MIX_A = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] K_MIX_B = 64'h94D049BB133111EB;

    // Operation codes.
    localparam logic OP_SEED = 1'b0;
    localparam logic OP_NEXT = 1'b1;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX_IN,
        ST_MUL_LL,
        ST_MUL_LH,
        ST_MUL_HL,
        ST_MUL_FIN,
        ST_MID,
        ST_STORE,
        ST_NXT_SCR,
        ST_NXT_FIN,
        ST_RESP
    } t_state;

    // Partial-product steps of the 64x64 low-half multiply.
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_LL,
        MUL_LH,
        MUL_HL,
        MUL_FIN
    } t_mul;

    // Kind of result to deliver.
    typedef enum logic [1:0] {
        KIND_SEED,
        KIND_FAULT,
        KIND_VALUE
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  accept;
        logic  z_mix30;
        logic  z_mix27;
        t_mul  mul;
        logic  const_b;
        logic  store_low;
        logic  store_high;
        logic  ctr_step;
        logic  nxt_scr;
        logic  nxt_fin;
        logic  out_load;
        t_kind kind;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

/* hw/rtl/prngsn_if.sv */
// Request and response channel interfaces of the random-number unit.
interface prngsn_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [63:0] seed_value;
    logic        user_mode;

    modport source (output valid, operation, seed_value, user_mode, input ready);
    modport sink (input valid, operation, seed_value, user_mode, output ready);
endinterface

interface prngsn_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] random_value;
    logic        value_valid;
    logic        privilege_fault;

    modport source (output valid, random_value, value_valid, privilege_fault, input ready);
    modport sink (input valid, random_value, value_valid, privilege_fault, output ready);
endinterface

/* hw/rtl/prng_seed_and_next_unit.sv */
// Top level of the random-number instruction unit (xoroshiro128** with splitmix64 seeding).
//
// Requests arrive on i_req (operation, seed_value, user_mode) and each gives exactly one
// response on o_rsp (random_value, value_valid, privilege_fault). A transfer happens on a
// rising edge where valid and ready are both high. Requests are taken one at a time.
// Steps from a request transfer to its response on o_rsp:
//   user mode (fault):  straight to ST_RESP, state left alone.
//   next:               ST_NXT_SCR and ST_NXT_FIN for the shift-add scrambler, with the state
//                       update in ST_NXT_FIN, then ST_RESP.
//   seed:               each splitmix64 mix runs two 64-bit multiplies on one
//                       shared 32x32 multiplier, stepping MUL_LL, MUL_LH, MUL_HL, MUL_FIN.
// With an always-ready receiver a new request can transfer only after the response
// of the previous one has been loaded into the output register.
// i_req.ready rises again the cycle after the response is loaded, so the next request
// may transfer while the response still waits in the output register. If the receiver
// stalls, the response holds and at most one further request is finished before the unit
// waits for the output register to drain.
// Reset (synchronous, active low) clears both state words to zero, so a next before any
// seed returns zero, and drops any pending response.

module prng_seed_and_next_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    prngsn_req_if.sink          i_req,
    prngsn_rsp_if.source        o_rsp
);

    prngsn_pkg::t_cmd w_cmd;
    prngsn_pkg::t_sts w_sts;
    logic             w_in_ready;

    assign i_req.ready = w_in_ready;

    prngsn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_operation (i_req.operation),
        .i_user_mode (i_req.user_mode),
        .o_in_ready  (w_in_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    prngsn_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_seed_value      (i_req.seed_value),
        .o_out_valid       (o_rsp.valid),
        .i_out_ready       (o_rsp.ready),
        .o_random_value    (o_rsp.random_value),
        .o_value_valid     (o_rsp.value_valid),
        .o_privilege_fault (o_rsp.privilege_fault)
    );

endmodule

/* hw/rtl/prngsn_ctrl.sv */
// Controller state machine of the random-number unit.
`include "prng_seed_and_next_unit_macros.svh"

module prngsn_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_operation,
    input  logic                i_user_mode,
    output logic                o_in_ready,
    output prngsn_pkg::t_cmd    o_cmd,
    input  prngsn_pkg::t_sts    i_sts
);

    prngsn_pkg::t_state r_state, n_state;
    prngsn_pkg::t_kind  r_kind, n_kind;
    logic               r_second, n_second;
    logic               r_const_b, n_const_b;
    logic               w_accept;

    assign w_accept = i_in_valid && (r_state == prngsn_pkg::ST_IDLE);

    // State and sequencing registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= prngsn_pkg::ST_IDLE;
            r_kind    <= prngsn_pkg::KIND_SEED;
            r_second  <= 1'b0;
            r_const_b <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_kind    <= n_kind;
            r_second  <= n_second;
            r_const_b <= n_const_b;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_second   = r_second;
        n_const_b  = r_const_b;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.mul  = prngsn_pkg::MUL_NONE;
        o_cmd.kind = r_kind;
        o_cmd.const_b = r_const_b;
        unique case (r_state)
            prngsn_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = w_accept;
                if (w_accept) begin
                    n_second  = 1'b0;
                    n_const_b = 1'b0;
                    if (i_user_mode) begin
                        n_kind  = prngsn_pkg::KIND_FAULT;
                        n_state = prngsn_pkg::ST_RESP;
                    end else if (i_operation == prngsn_pkg::OP_NEXT) begin
                        n_kind  = prngsn_pkg::KIND_VALUE;
                        n_state = prngsn_pkg::ST_NXT_SCR;
                    end else begin
                        n_kind  = prngsn_pkg::KIND_SEED;
                        n_state = prngsn_pkg::ST_MIX_IN;
                    end
                end
            end
            prngsn_pkg::ST_MIX_IN: begin
                o_cmd.z_mix30 = 1'b1;
                n_state       = prngsn_pkg::ST_MUL_LL;
            end
            prngsn_pkg::ST_MUL_LL: begin
                o_cmd.mul = prngsn_pkg::MUL_LL;
                n_state   = prngsn_pkg::ST_MUL_LH;
            end
            prngsn_pkg::ST_MUL_LH: begin
                o_cmd.mul = prngsn_pkg::MUL_LH;
                n_state   = prngsn_pkg::ST_MUL_HL;
            end
            prngsn_pkg::ST_MUL_HL: begin
                o_cmd.mul = prngsn_pkg::MUL_HL;
                n_state   = prngsn_pkg::ST_MUL_FIN;
            end
            prngsn_pkg::ST_MUL_FIN: begin
                o_cmd.mul = prngsn_pkg::MUL_FIN;
                if (r_const_b) begin
                    n_state = prngsn_pkg::ST_STORE;
                end else begin
                    n_const_b = 1'b1;
                    n_state   = prngsn_pkg::ST_MID;
                end
            end
            prngsn_pkg::ST_MID: begin
                o_cmd.z_mix27 = 1'b1;
                n_state       = prngsn_pkg::ST_MUL_LL;
            end
            prngsn_pkg::ST_STORE: begin
                if (r_second) begin
                    o_cmd.store_high = 1'b1;
                    n_state          = prngsn_pkg::ST_RESP;
                end else begin
                    o_cmd.store_low = 1'b1;
                    o_cmd.ctr_step  = 1'b1;
                    n_second        = 1'b1;
                    n_const_b       = 1'b0;
                    n_state         = prngsn_pkg::ST_MIX_IN;
                end
            end
            prngsn_pkg::ST_NXT_SCR: begin
                o_cmd.nxt_scr = 1'b1;
                n_state       = prngsn_pkg::ST_NXT_FIN;
            end
            prngsn_pkg::ST_NXT_FIN: begin
                o_cmd.nxt_fin = 1'b1;
                n_state       = prngsn_pkg::ST_RESP;
            end
            prngsn_pkg::ST_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = prngsn_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = prngsn_pkg::ST_IDLE;
            end
        endcase
    end

    // A refused request goes straight to the response.
    `PRNGSN_ASSERT(a_fault_direct, i_clk, i_rst_n,
        w_accept && i_user_mode |=> r_state == prngsn_pkg::ST_RESP)
    // The second multiply of a mix ends the mix.
    `PRNGSN_ASSERT(a_mix_done, i_clk, i_rst_n,
        r_state == prngsn_pkg::ST_MUL_FIN && r_const_b |=> r_state == prngsn_pkg::ST_STORE)
    // A response that finds the output free is handed over at once.
    `PRNGSN_ASSERT(a_resp_leaves, i_clk, i_rst_n,
        r_state == prngsn_pkg::ST_RESP && i_sts.out_free |=> r_state == prngsn_pkg::ST_IDLE)

endmodule

/* hw/rtl/prngsn_dp.sv */
// Datapath of the random-number unit: state words, shared multiplier, output register.
`include "prng_seed_and_next_unit_macros.svh"

module prngsn_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  prngsn_pkg::t_cmd    i_cmd,
    output prngsn_pkg::t_sts    o_sts,
    input  logic [63:0]         i_seed_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [63:0]         o_random_value,
    output logic                o_value_valid,
    output logic                o_privilege_fault
);

    logic [63:0] r_s0, r_s1;
    logic [63:0] r_ctr;
    logic [63:0] r_z;
    logic [63:0] r_acc;
    logic [63:0] r_prod;
    logic [63:0] r_val;
    logic        r_out_valid;
    logic [63:0] r_rand;
    logic        r_vv;
    logic        r_pf;

    logic [63:0] w_k;
    logic [31:0] w_mul_a, w_mul_b;
    logic [63:0] w_prod;
    logic [63:0] w_x5;
    logic [63:0] w_t;

    // Operand selection for one 32x32 partial product.
    always_comb begin
        w_k     = i_cmd.const_b ? prngsn_pkg::K_MIX_B : prngsn_pkg::K_MIX_A;
        w_mul_a = (i_cmd.mul == prngsn_pkg::MUL_HL) ? r_z[63:32] : r_z[31:0];
        w_mul_b = (i_cmd.mul == prngsn_pkg::MUL_LH) ? w_k[63:32] : w_k[31:0];
        w_prod  = 64'(w_mul_a) * 64'(w_mul_b);
        w_x5    = r_s0 + {r_s0[61:0], 2'b00};
        w_t     = r_s1 ^ r_s0;
    end

    // Generator state words, reset to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0 <= '0;
            r_s1 <= '0;
        end else if (i_cmd.store_low) begin
            r_s0 <= r_acc ^ {31'b0, r_acc[63:31]};
        end else if (i_cmd.store_high) begin
            r_s1 <= r_acc ^ {31'b0, r_acc[63:31]};
        end else if (i_cmd.nxt_fin) begin
            r_s0 <= {r_s0[39:0], r_s0[63:40]} ^ w_t ^ {w_t[47:0], 16'b0};
            r_s1 <= {w_t[26:0], w_t[63:27]};
        end
    end

    // Splitmix counter, mix value, product and accumulator.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ctr <= i_seed_value + prngsn_pkg::K_GAMMA;
        end else if (i_cmd.ctr_step) begin
            r_ctr <= r_ctr + prngsn_pkg::K_GAMMA;
        end
        if (i_cmd.z_mix30) begin
            r_z <= r_ctr ^ {30'b0, r_ctr[63:30]};
        end else if (i_cmd.z_mix27) begin
            r_z <= r_acc ^ {27'b0, r_acc[63:27]};
        end else if (i_cmd.nxt_scr) begin
            r_z <= {w_x5[56:0], w_x5[63:57]};
        end
        r_prod <= w_prod;
        case (i_cmd.mul)
            prngsn_pkg::MUL_LH: r_acc <= r_prod;
            prngsn_pkg::MUL_HL,
            prngsn_pkg::MUL_FIN: r_acc <= r_acc + {r_prod[31:0], 32'b0};
            default: r_acc <= r_acc;
        endcase
        if (i_cmd.nxt_fin) begin
            r_val <= r_z + {r_z[60:0], 3'b000};
        end
    end

    // Output register: holds one result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_rand <= (i_cmd.kind == prngsn_pkg::KIND_VALUE) ? r_val : 64'b0;
            r_vv   <= (i_cmd.kind == prngsn_pkg::KIND_VALUE);
            r_pf   <= (i_cmd.kind == prngsn_pkg::KIND_FAULT);
        end
    end

    assign o_sts.out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_random_value    = r_rand;
    assign o_value_valid     = r_vv;
    assign o_privilege_fault = r_pf;

    // An all-zero state stays all zero through a next step.
    `PRNGSN_ASSERT(a_zero_state, i_clk, i_rst_n,
        i_cmd.nxt_fin && r_s0 == 64'b0 && r_s1 == 64'b0 |=> r_s0 == 64'b0 && r_s1 == 64'b0)
    // A loaded result is presented in the next cycle.
    `PRNGSN_ASSERT(a_load_shows, i_clk, i_rst_n, i_cmd.out_load |=> r_out_valid)
    // A result is never loaded over one that the receiver has not taken.
    `PRNGSN_ASSERT_ALWAYS(a_no_overwrite, i_clk,
        !(i_cmd.out_load && r_out_valid && !i_out_ready))

endmodule

/* tb/sv/tb_prng_seed_and_next_unit.sv */
// Self-checking testbench for the xoroshiro128** random-number unit with splitmix64 seeding.
`timescale 1ns / 100ps

module tb_prng_seed_and_next_unit;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 30;
    localparam int unsigned PRINT_CAP     = 100;

    // One response of the unit, in the order of its fields.
    typedef struct packed {
        logic [63:0] random_value;
        logic        value_valid;
        logic        privilege_fault;
    } t_rng_result;

    // Keeps its own generator state and the queue of responses still owed.
    class rng_scoreboard;
        logic [63:0] word_low;
        logic [63:0] word_high;
        t_rng_result owed_q[$];
        int unsigned error_count;
        int unsigned response_count;

        function new();
            word_low       = '0;
            word_high      = '0;
            error_count    = 0;
            response_count = 0;
        endfunction

        function logic [63:0] rotl64(logic [63:0] v, int unsigned amount);
            return (v << amount) | (v >> (64 - amount));
        endfunction

        // Splitmix64 finalizer.
        function logic [63:0] splitmix_mix(logic [63:0] z);
            logic [63:0] m;
            m = (z ^ (z >> 30)) * prngsn_pkg::K_MIX_A;
            m = (m ^ (m >> 27)) * prngsn_pkg::K_MIX_B;
            return m ^ (m >> 31);
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction

        // Works out the response to an accepted request and advances the state.
        function void note_request(logic op, logic [63:0] seed, logic user);
            t_rng_result owed;
            logic [63:0] counter;
            logic [63:0] s0;
            logic [63:0] t;
            owed = '0;
            if (user) begin
                // Refused in user mode; the state stays as it was.
                owed.privilege_fault = 1'b1;
            end else if (op == prngsn_pkg::OP_SEED) begin
                counter   = seed + prngsn_pkg::K_GAMMA;
                word_low  = splitmix_mix(counter);
                counter   = counter + prngsn_pkg::K_GAMMA;
                word_high = splitmix_mix(counter);
            end else begin
                s0                 = word_low;
                t                  = word_high ^ s0;
                owed.random_value  = rotl64(s0 * 64'd5, 7) * 64'd9;
                owed.value_valid   = 1'b1;
                word_low           = rotl64(s0, 24) ^ t ^ (t << 16);
                word_high          = rotl64(t, 37);
            end
            owed_q.push_back(owed);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            if (error_count < PRINT_CAP)
                $display("MISMATCH response %0d %s: got %h, expected %h",
                         response_count, what, got, want);
            error_count++;
        endtask

        // Compares one accepted response with the oldest one owed.
        task check_response(t_rng_result got);
            t_rng_result want;
            if (owed_q.size() == 0) begin
                report_mismatch("unexpected response", got.random_value, '0);
            end else begin
                want = owed_q.pop_front();
                if (got.random_value !== want.random_value)
                    report_mismatch("random_value", got.random_value, want.random_value);
                if (got.value_valid !== want.value_valid)
                    report_mismatch("value_valid", 64'(got.value_valid),
                                    64'(want.value_valid));
                if (got.privilege_fault !== want.privilege_fault)
                    report_mismatch("privilege_fault", 64'(got.privilege_fault),
                                    64'(want.privilege_fault));
            end
            response_count++;
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned rsp_hold_cycles;
    rng_scoreboard sb;

    prngsn_req_if req_if();
    prngsn_rsp_if rsp_if();

    prng_seed_and_next_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // Clock generation.
    always #2 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Response side: checks each transfer and decides ready for the next cycle.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
                sb.check_response({rsp_if.random_value, rsp_if.value_valid,
                                   rsp_if.privilege_fault});
            if (rsp_hold_cycles > 0) begin
                rsp_hold_cycles--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offers one request, with an optional random gap first, and waits for its transfer.
    task automatic send_request(logic op, logic [63:0] seed, logic user);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        req_if.valid      <= 1'b1;
        req_if.operation  <= op;
        req_if.seed_value <= seed;
        req_if.user_mode  <= user;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        sb.note_request(op, seed, user);
    endtask

    // Stops offering and waits until every owed response has arrived.
    task automatic wait_for_drain();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Mostly next operations with occasional reseeds and user-mode faults.
    task automatic run_random_requests(int unsigned count);
        logic        op;
        logic        user;
        logic [63:0] seed;
        for (int unsigned k = 0; k < count; k++) begin
            op   = ($urandom_range(99) < 70) ? prngsn_pkg::OP_NEXT : prngsn_pkg::OP_SEED;
            user = ($urandom_range(99) < 10);
            case ($urandom_range(9))
                0: seed = '0;
                1: seed = '1;
                2: seed = 64'h1 << $urandom_range(63);
                default: seed = {$urandom, $urandom};
            endcase
            send_request(op, seed, user);
        end
    endtask

    // Main sequence.
    initial begin
        sb                = new();
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        cycle_count       = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        rsp_hold_cycles   = 0;
        req_if.valid      = 1'b0;
        req_if.operation  = prngsn_pkg::OP_SEED;
        req_if.seed_value = '0;
        req_if.user_mode  = 1'b0;
        rsp_if.ready      = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Next from the all-zero reset state returns zero and keeps it zero.
        send_request(prngsn_pkg::OP_NEXT, '0, 1'b0);
        send_request(prngsn_pkg::OP_NEXT, '1, 1'b0);
        // User mode faults on both operations and leaves the state alone.
        send_request(prngsn_pkg::OP_SEED, '1, 1'b1);
        send_request(prngsn_pkg::OP_NEXT, '0, 1'b1);
        send_request(prngsn_pkg::OP_NEXT, '0, 1'b0);
        // Seed extremes, each followed by one or two outputs; the 5555 seed is sent in user mode and faults.
        send_request(prngsn_pkg::OP_SEED, '0, 1'b0);
        send_request(prngsn_pkg::OP_NEXT, '0, 1'b0);
        send_request(prngsn_pkg::OP_NEXT, '0, 1'b0);
        send_request(prngsn_pkg::OP_SEED, '1, 1'b0);
        send_request(prngsn_pkg::OP_NEXT, '1, 1'b0);
        send_request(prngsn_pkg::OP_NEXT, '1, 1'b0);
        send_request(prngsn_pkg::OP_SEED, 64'h8000_0000_0000_0000, 1'b0);
        send_request(prngsn_pkg::OP_NEXT, '0, 1'b0);
        send_request(prngsn_pkg::OP_SEED, 64'h0000_0000_0000_0001, 1'b0);
        send_request(prngsn_pkg::OP_NEXT, '0, 1'b0);
        send_request(prngsn_pkg::OP_SEED, 64'h5555_5555_5555_5555, 1'b1);
        send_request(prngsn_pkg::OP_NEXT, '0, 1'b1);
        send_request(prngsn_pkg::OP_NEXT, '0, 1'b0);
        send_request(prngsn_pkg::OP_SEED, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_request(prngsn_pkg::OP_NEXT, '0, 1'b0);
        send_request(prngsn_pkg::OP_NEXT, '0, 1'b0);
        wait_for_drain();

        // Random phases with different amounts of idling on each side.
        run_random_requests(350);
        wait_for_drain();
        send_idle_pct  = 52;
        recv_stall_pct = 0;
        run_random_requests(350);
        wait_for_drain();
        send_idle_pct  = 0;
        recv_stall_pct = 52;
        run_random_requests(350);
        wait_for_drain();

        // Long receiver hold-off while requests keep coming, so the input stalls.
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        rsp_hold_cycles = 300;
        run_random_requests(20);
        wait_for_drain();

        send_idle_pct  = 34;
        recv_stall_pct = 34;
        run_random_requests(350);
        wait_for_drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_requests(200);
        wait_for_drain();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
